FILE: rtl/ncst_pkg.sv
// Package: constants and types for the named counting semaphore table
package ncst_pkg;
	localparam int SLOT_COUNT  = 8;
	localparam int QUEUE_DEPTH = 16;
	localparam int TASK_LIMIT  = 64;
	localparam int SLOT_W      = $clog2(SLOT_COUNT);
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int TASK_W      = $clog2(TASK_LIMIT);
	localparam int STORE_DEPTH = SLOT_COUNT * QUEUE_DEPTH;
	localparam int STORE_W     = $clog2(STORE_DEPTH);
	localparam int NAME_BYTES  = 15;

	typedef enum logic [1:0] {
		OP_OPEN   = 2'd0,
		OP_WAIT   = 2'd1,
		OP_POST   = 2'd2,
		OP_UNLINK = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_SLOT   = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_QUEUE_FULL = 2'd3
	} status_t;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [63:0] name_low;
		logic [55:0] name_high;
		logic [14:0] init_count;
		logic [2:0]  slot_index;
		logic [5:0]  task_id;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [2:0]         handle;
		logic               must_sleep;
		logic               wake_valid;
		logic [5:0]         wake_task;
		logic signed [15:0] count_after;
	} rsp_t;

	typedef struct packed {
		logic [63:0] lo;
		logic [55:0] hi;
	} name_t;

	// zero every byte after the first zero byte
	function automatic name_t canon_name(input logic [63:0] lo, input logic [55:0] hi);
		logic [8*NAME_BYTES-1:0] w;
		logic ended;
		name_t r;
		w = {hi, lo};
		ended = 1'b0;
		for (int b = 0; b < NAME_BYTES; b++) begin
			if (ended) w[8*b +: 8] = 8'd0;
			else if (w[8*b +: 8] == 8'd0) ended = 1'b1;
		end
		r.lo = w[63:0];
		r.hi = w[119:64];
		return r;
	endfunction
endpackage

FILE: rtl/ncst_if.sv
// Interface: valid/ready channel carrying one payload
interface ncst_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/named_counting_semaphore_table.sv
// Named counting semaphore table: one request in, one result out, each request passing
// through name match and memory read, then modify and write back; the waiter store
// is a synchronous memory of SLOT_COUNT*QUEUE_DEPTH task ids with a registered read,
// and a new request is taken only when stage 2 is idle and the output register is empty
// or being read; one request is in flight at a time, so no forwarding is needed.
module named_counting_semaphore_table (
	input logic clk,
	input logic arst_n,
	ncst_if.sink   req,
	ncst_if.source rsp
);
	import ncst_pkg::*;

	logic                     used_q [SLOT_COUNT];
	logic signed [15:0]       count_q [SLOT_COUNT];
	logic [63:0]              nlo_q [SLOT_COUNT];
	logic [55:0]              nhi_q [SLOT_COUNT];
	logic [QPTR_W-1:0]        head_q [SLOT_COUNT];
	logic [QPTR_W-1:0]        tail_q [SLOT_COUNT];
	logic [TASK_W-1:0]        store_mem [STORE_DEPTH];
	logic [TASK_W-1:0]        store_rd_s2;

	logic                     busy_s2;
	req_t                     req_s2;
	logic                     found_s2, free_s2;
	logic [SLOT_W-1:0]        match_s2, free_idx_s2;
	name_t                    name_s2;
	logic                     out_valid_q;
	rsp_t                     out_q;

	name_t                    cn;
	logic                     found;
	logic                     free_any;
	logic [SLOT_W-1:0]        match_idx, free_idx;

	always_comb begin
		cn = canon_name(req.data.name_low, req.data.name_high);
		found = 1'b0;
		match_idx = '0;
		free_any = 1'b0;
		free_idx = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (used_q[i] && nlo_q[i] == cn.lo && nhi_q[i] == cn.hi) begin
				found = 1'b1;
				match_idx = SLOT_W'(i);
			end
			if (!used_q[i]) begin
				free_any = 1'b1;
				free_idx = SLOT_W'(i);
			end
		end
	end

	assign req.ready = !busy_s2 && (!out_valid_q || rsp.ready);
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	logic req_fire;
	assign req_fire = req.valid && req.ready;

	// waiter store: one read port, one write port
	logic                 st_we;
	logic [STORE_W-1:0]   st_waddr, st_raddr;
	logic [TASK_W-1:0]    st_wdata;
	logic [SLOT_W-1:0]    rd_slot;
	assign rd_slot  = req.data.slot_index[SLOT_W-1:0];
	assign st_raddr = {rd_slot, head_q[rd_slot]};

	always_ff @(posedge clk) begin
		if (req_fire) store_rd_s2 <= store_mem[st_raddr];
		if (st_we) store_mem[st_waddr] <= st_wdata;
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_s2      <= req.data;
			name_s2     <= cn;
			found_s2    <= found;
			match_s2    <= match_idx;
			free_s2     <= free_any;
			free_idx_s2 <= free_idx;
		end
	end

	// stage 2 combinational result
	rsp_t               res;
	logic [SLOT_W-1:0]  ix;
	logic signed [15:0] c, n;
	logic               idx_ok;
	logic [QPTR_W-1:0]  nt;
	always_comb begin
		res = '0;
		ix = req_s2.slot_index[SLOT_W-1:0];
		idx_ok = ({1'b0, req_s2.slot_index} < 4'(SLOT_COUNT)) && used_q[ix];
		c = count_q[ix];
		n = c;
		nt = tail_q[ix] + 1'b1;
		st_we = 1'b0;
		st_waddr = {ix, tail_q[ix]};
		st_wdata = req_s2.task_id[TASK_W-1:0];
		unique case (opcode_t'(req_s2.opcode))
			OP_OPEN: begin
				if (found_s2) begin
					res.handle = 3'(match_s2);
					res.count_after = count_q[match_s2];
				end else if (free_s2) begin
					res.handle = 3'(free_idx_s2);
					res.count_after = {1'b0, req_s2.init_count};
				end else res.status = ST_NO_SLOT;
			end
			OP_UNLINK: begin
				if (found_s2) res.handle = 3'(match_s2);
				else res.status = ST_NOT_FOUND;
			end
			OP_WAIT: begin
				if (!idx_ok) res.status = ST_NOT_FOUND;
				else begin
					res.handle = req_s2.slot_index;
					n = (c != -16'sd32768) ? c - 16'sd1 : c;
					if (n < 0) begin
						if (nt == head_q[ix]) begin
							res.status = ST_QUEUE_FULL;
							n = c;
						end else begin
							st_we = 1'b1;
							res.must_sleep = 1'b1;
						end
					end
					res.count_after = n;
				end
			end
			OP_POST: begin
				if (!idx_ok) res.status = ST_NOT_FOUND;
				else begin
					res.handle = req_s2.slot_index;
					n = (c != 16'sd32767) ? c + 16'sd1 : c;
					if (n <= 0 && head_q[ix] != tail_q[ix]) begin
						res.wake_valid = 1'b1;
						res.wake_task = 6'(store_rd_s2);
					end
					res.count_after = n;
				end
			end
			default: ;
		endcase
		if (!busy_s2) st_we = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s2 <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				used_q[i] <= 1'b0;
				count_q[i] <= '0;
				nlo_q[i] <= '0;
				nhi_q[i] <= '0;
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
		end else begin
			out_valid_q <= busy_s2 || (out_valid_q && !rsp.ready);
			busy_s2 <= req_fire;
			if (busy_s2) begin
				out_q <= res;
				unique case (opcode_t'(req_s2.opcode))
					OP_OPEN: begin
						if (!found_s2 && free_s2) begin
							used_q[free_idx_s2]  <= 1'b1;
							nlo_q[free_idx_s2]   <= name_s2.lo;
							nhi_q[free_idx_s2]   <= name_s2.hi;
							count_q[free_idx_s2] <= {1'b0, req_s2.init_count};
							head_q[free_idx_s2]  <= '0;
							tail_q[free_idx_s2]  <= '0;
						end
					end
					OP_UNLINK: begin
						if (found_s2) begin
							used_q[match_s2]  <= 1'b0;
							count_q[match_s2] <= '0;
							nlo_q[match_s2]   <= '0;
							nhi_q[match_s2]   <= '0;
						end
					end
					OP_WAIT: begin
						if (idx_ok) begin
							count_q[ix] <= n;
							if (res.must_sleep) tail_q[ix] <= nt;
						end
					end
					OP_POST: begin
						if (idx_ok) begin
							count_q[ix] <= n;
							if (res.wake_valid) head_q[ix] <= head_q[ix] + 1'b1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	assign_sleep_wake: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.data.must_sleep && rsp.data.wake_valid))
		else $error("sleep and wake in one result");
	no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_s2 |-> !req.ready)
		else $error("request taken while busy");
	result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> busy_s2)
		else $error("accepted request lost");
endmodule
